[hw/rtl/ssc_pkg.sv]
package ssc_pkg;

    localparam int CAPACITY = 64;

    localparam int KEY_W  = 16;
    localparam int TOT_W  = 16;
    localparam int DIV_W  = 4;
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int GAP_W  = $clog2(CAPACITY / 2 + 1);
    localparam int IDX_W  = $clog2(CAPACITY + CAPACITY / 2);
    localparam int CMP_W  = CNT_W + DIV_W;

    localparam logic [DIV_W-1:0] DIV_MIN   = DIV_W'(2);
    localparam logic [DIV_W-1:0] DIV_MAX   = DIV_W'(8);
    localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(2);

    localparam logic [TOT_W-1:0] TOT_MAX        = '1;
    localparam logic [TOT_W-1:0] MOVES_PER_SWAP = TOT_W'(3);

    typedef struct packed {
        logic [TOT_W-1:0] move_total;
        logic [TOT_W-1:0] compare_total;
        logic             final_item;
        logic [KEY_W-1:0] sorted_value;
    } result_t;

endpackage

[hw/rtl/ssc_ram.sv]
module ssc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ssc_core.sv]
module ssc_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ssc_pkg::DIV_W-1:0]  divisor,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ssc_pkg::KEY_W-1:0]  in_key,
    input  logic                       in_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ssc_pkg::result_t           out_result
);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_NEXT_I = 3'd2;
    localparam logic [2:0] ST_KEY    = 3'd3;
    localparam logic [2:0] ST_CMP    = 3'd4;
    localparam logic [2:0] ST_PUT    = 3'd5;
    localparam logic [2:0] ST_EOUT   = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [ssc_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [ssc_pkg::CNT_W-1:0]   n_reg, n_next;
    logic [ssc_pkg::GAP_W-1:0]   gap_reg, gap_next;
    logic [ssc_pkg::GAP_W-1:0]   last_gap_reg, last_gap_next;
    logic [ssc_pkg::GAP_W-1:0]   start_reg, start_next;
    logic [ssc_pkg::IDX_W-1:0]   i_reg, i_next;
    logic [ssc_pkg::ADDR_W-1:0]  j_reg, j_next;
    logic [ssc_pkg::ADDR_W-1:0]  k_reg, k_next;
    logic [ssc_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [ssc_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [ssc_pkg::GAP_W-1:0]   quot_reg, quot_next;
    logic [ssc_pkg::TOT_W-1:0]   cmp_reg, cmp_next;
    logic [ssc_pkg::TOT_W-1:0]   mov_reg, mov_next;

    logic                        ram_we;
    logic [ssc_pkg::ADDR_W-1:0]  ram_waddr;
    logic [ssc_pkg::KEY_W-1:0]   ram_wdata;
    logic                        ram_re;
    logic [ssc_pkg::ADDR_W-1:0]  ram_raddr;
    logic [ssc_pkg::KEY_W-1:0]   ram_rdata;

    logic [ssc_pkg::CMP_W-1:0]   rem_ext, div_ext;
    logic [ssc_pkg::IDX_W-1:0]   gap_idx, start_idx, j_idx, n_idx;
    logic [ssc_pkg::ADDR_W-1:0]  j_up;
    logic [ssc_pkg::CNT_W-1:0]   n_load;
    logic                        is_final;

    ssc_ram #(
        .WIDTH(ssc_pkg::KEY_W),
        .DEPTH(ssc_pkg::CAPACITY)
    ) u_key_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rem_ext   = ssc_pkg::CMP_W'(rem_reg);
    assign div_ext   = ssc_pkg::CMP_W'(divisor);
    assign gap_idx   = ssc_pkg::IDX_W'(gap_reg);
    assign start_idx = ssc_pkg::IDX_W'(start_reg);
    assign j_idx     = ssc_pkg::IDX_W'(j_reg);
    assign n_idx     = ssc_pkg::IDX_W'(n_reg);
    assign j_up      = ssc_pkg::ADDR_W'(j_idx + gap_idx);
    assign n_load    = (count_reg < ssc_pkg::CNT_W'(ssc_pkg::CAPACITY))
                     ? count_reg + ssc_pkg::CNT_W'(1) : count_reg;
    assign is_final  = (ssc_pkg::CNT_W'(k_reg) + ssc_pkg::CNT_W'(1)) == n_reg;

    assign in_ready   = (state_reg == ST_LOAD);
    assign out_valid  = (state_reg == ST_EOUT);
    assign out_result = {mov_reg, cmp_reg, is_final, ram_rdata};

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        gap_next      = gap_reg;
        last_gap_next = last_gap_reg;
        start_next    = start_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        key_next      = key_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        cmp_next      = cmp_reg;
        mov_next      = mov_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_valid) begin
                    if (count_reg < ssc_pkg::CNT_W'(ssc_pkg::CAPACITY)) begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[ssc_pkg::ADDR_W-1:0];
                        ram_wdata  = in_key;
                        count_next = count_reg + ssc_pkg::CNT_W'(1);
                    end
                    if (in_last) begin
                        n_next        = n_load;
                        count_next    = '0;
                        cmp_next      = '0;
                        mov_next      = '0;
                        last_gap_next = '0;
                        rem_next      = n_load;
                        quot_next     = '0;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (rem_ext >= div_ext) begin
                    rem_next  = ssc_pkg::CNT_W'(rem_ext - div_ext);
                    quot_next = quot_reg + ssc_pkg::GAP_W'(1);
                end else if (quot_reg != '0) begin
                    gap_next      = quot_reg;
                    last_gap_next = quot_reg;
                    start_next    = '0;
                    i_next        = ssc_pkg::IDX_W'(quot_reg);
                    state_next    = ST_NEXT_I;
                end else if (last_gap_reg != ssc_pkg::GAP_W'(1)) begin
                    // gap sequence skipped one: finish with a plain insertion pass
                    gap_next      = ssc_pkg::GAP_W'(1);
                    last_gap_next = ssc_pkg::GAP_W'(1);
                    start_next    = '0;
                    i_next        = ssc_pkg::IDX_W'(1);
                    state_next    = ST_NEXT_I;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    k_next     = '0;
                    state_next = ST_EOUT;
                end
            end
            ST_NEXT_I: begin
                if (i_reg < n_idx) begin
                    ram_re     = 1'b1;
                    ram_raddr  = i_reg[ssc_pkg::ADDR_W-1:0];
                    state_next = ST_KEY;
                end else if ((start_idx + ssc_pkg::IDX_W'(1)) < gap_idx) begin
                    start_next = start_reg + ssc_pkg::GAP_W'(1);
                    i_next     = start_idx + ssc_pkg::IDX_W'(1) + gap_idx;
                end else begin
                    rem_next   = ssc_pkg::CNT_W'(gap_reg);
                    quot_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_KEY: begin
                key_next   = ram_rdata;
                j_next     = ssc_pkg::ADDR_W'(i_reg - gap_idx);
                ram_re     = 1'b1;
                ram_raddr  = ssc_pkg::ADDR_W'(i_reg - gap_idx);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmp_next = (cmp_reg == ssc_pkg::TOT_MAX)
                         ? cmp_reg : cmp_reg + ssc_pkg::TOT_W'(1);
                ram_we    = 1'b1;
                ram_waddr = j_up;
                if (ram_rdata > key_reg) begin
                    ram_wdata = ram_rdata;
                    mov_next  = (mov_reg > (ssc_pkg::TOT_MAX - ssc_pkg::MOVES_PER_SWAP))
                              ? ssc_pkg::TOT_MAX : mov_reg + ssc_pkg::MOVES_PER_SWAP;
                    if (j_idx < (start_idx + gap_idx)) begin
                        state_next = ST_PUT;
                    end else begin
                        j_next    = ssc_pkg::ADDR_W'(j_idx - gap_idx);
                        ram_re    = 1'b1;
                        ram_raddr = ssc_pkg::ADDR_W'(j_idx - gap_idx);
                    end
                end else begin
                    ram_wdata  = key_reg;
                    i_next     = i_reg + gap_idx;
                    state_next = ST_NEXT_I;
                end
            end
            ST_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = key_reg;
                i_next     = i_reg + gap_idx;
                state_next = ST_NEXT_I;
            end
            ST_EOUT: begin
                if (out_ready) begin
                    if (is_final) begin
                        state_next = ST_LOAD;
                    end else begin
                        k_next    = k_reg + ssc_pkg::ADDR_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = k_reg + ssc_pkg::ADDR_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            cmp_reg   <= '0;
            mov_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            cmp_reg   <= cmp_next;
            mov_reg   <= mov_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        gap_reg      <= gap_next;
        last_gap_reg <= last_gap_next;
        start_reg    <= start_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        key_reg      <= key_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ssc_pkg::CNT_W'(ssc_pkg::CAPACITY))
        else $error("load count past capacity");

    a_gap_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NEXT_I || state_reg == ST_KEY || state_reg == ST_CMP ||
         state_reg == ST_PUT) |-> (gap_reg != '0))
        else $error("sort pass running with zero gap");

    a_cmp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (ssc_pkg::CNT_W'(j_up) < n_reg))
        else $error("compare step outside loaded keys");

    a_totals_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EOUT && $past(state_reg == ST_EOUT))
        |-> ($stable(cmp_reg) && $stable(mov_reg)))
        else $error("totals changed during output");

    a_move_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP && $past(state_reg == ST_CMP)) |-> (cmp_reg != '0))
        else $error("compare total lost a step");
`endif

endmodule

[hw/rtl/shell_sort_with_counts.sv]
// Collects up to ssc_pkg::CAPACITY unsigned 16-bit keys, one per cycle, until a
// request with tlast set; keys past capacity are dropped, but their tlast still
// starts the sort. The keys are then shell-sorted in place in a single-port-read,
// single-port-write key memory, gaps being count/divisor, divided again each round
// (divisor clamped to 2..8, plus a closing gap-1 pass when the sequence misses 1).
// Each comparison is one compare state; each inserted key also passes a read state and a
// key-fetch state, plus a put state when it lands at the head of its chain, and each
// chain change and each gap division step is a state of its own.
// Results then stream out one per cycle while the receiver is ready, in ascending
// order, each carrying the saturating compare and move totals, tlast on the last. Input
// is stalled from the end-of-set request until the last result has moved into the
// output register. No clearing pass at reset.
module shell_sort_with_counts (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,     // gap_divisor
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] key_value
    input  logic        s_axis_tlast,    // end_of_set
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,    // [15:0] sorted_value, [31:16] compare_total,
                                         // [47:32] move_total
    output logic        m_axis_tlast     // final_item
);

    logic [ssc_pkg::DIV_W-1:0] div_reg, div_next;
    logic [ssc_pkg::DIV_W-1:0] div_eff;
    logic                      m_valid_reg, m_valid_next;
    ssc_pkg::result_t          m_result_reg;
    ssc_pkg::result_t          core_result;
    logic                      core_valid;
    logic                      core_ready;

    assign div_next = cfg_wr_en ? cfg_wr_data : div_reg;
    assign div_eff  = (div_reg < ssc_pkg::DIV_MIN) ? ssc_pkg::DIV_MIN
                    : (div_reg > ssc_pkg::DIV_MAX) ? ssc_pkg::DIV_MAX : div_reg;

    ssc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .divisor   (div_eff),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_key    (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_result(core_result)
    );

    assign core_ready   = !m_valid_reg || m_axis_tready;
    assign m_valid_next = core_ready ? core_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg     <= ssc_pkg::DIV_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            div_reg     <= div_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_ready && core_valid) begin
            m_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_result_reg.move_total, m_result_reg.compare_total,
                            m_result_reg.sorted_value};
    assign m_axis_tlast  = m_result_reg.final_item;

endmodule

[tb/ssc_checker.sv]
`timescale 1ns / 100ps
module ssc_checker
    import ssc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [DIV_W-1:0] cfg_wr_data,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,
    input  logic             s_axis_tlast,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [47:0]      m_axis_tdata,
    input  logic             m_axis_tlast,
    output int               err_count,
    output int               pending
);

    logic [KEY_W-1:0] key_buf [CAPACITY];
    int unsigned      key_cnt;
    logic [DIV_W-1:0] divisor;
    int unsigned      cmp_sum;
    int unsigned      move_sum;
    result_t          sorted_q [$];

    function automatic int unsigned sat_add(int unsigned a, int unsigned amt);
        return (a + amt > TOT_MAX) ? TOT_MAX : a + amt;
    endfunction

    function automatic void sort_chain(int unsigned start, int unsigned n, int unsigned gap);
        int unsigned      i;
        int unsigned      j;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] t;
        bit               done;
        for (i = start + gap; i < n; i += gap) begin
            key  = key_buf[i];
            j    = i - gap;
            done = 0;
            while (!done) begin
                cmp_sum = sat_add(cmp_sum, 1);
                if (key_buf[j] > key) begin
                    t                = key_buf[j + gap];
                    key_buf[j + gap] = key_buf[j];
                    key_buf[j]       = t;
                    move_sum         = sat_add(move_sum, MOVES_PER_SWAP);
                    if (j < start + gap)
                        done = 1;
                    else
                        j -= gap;
                end else begin
                    done = 1;
                end
            end
        end
    endfunction

    function automatic void shell_sort_keys(int unsigned n);
        int unsigned d;
        int unsigned gap;
        int unsigned last_gap;
        int unsigned s;
        d = (divisor < DIV_MIN) ? DIV_MIN : (divisor > DIV_MAX) ? DIV_MAX : divisor;
        last_gap = 0;
        for (gap = n / d; gap > 0; gap = gap / d) begin
            for (s = 0; s < gap; s++)
                sort_chain(s, n, gap);
            last_gap = gap;
        end
        // closing gap-1 pass when the sequence never hit 1
        if (last_gap != 1)
            sort_chain(0, n, 1);
    endfunction

    function automatic void flag(string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    always @(posedge aclk) begin : watch
        result_t     want;
        int unsigned k;
        if (!aresetn) begin
            sorted_q.delete();
            key_cnt   = 0;
            divisor   = DIV_RESET;
            cmp_sum   = 0;
            move_sum  = 0;
            err_count = 0;
        end else begin
            if (cfg_wr_en)
                divisor = cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready) begin
                if (sorted_q.size() == 0) begin
                    flag($sformatf("result with none pending: tdata %h tlast %b",
                                   m_axis_tdata, m_axis_tlast));
                end else begin
                    want = sorted_q.pop_front();
                    if (m_axis_tdata[15:0] !== want.sorted_value)
                        flag($sformatf("sorted_value: expected %0d, got %0d",
                                       want.sorted_value, m_axis_tdata[15:0]));
                    if (m_axis_tlast !== want.final_item)
                        flag($sformatf("final_item: expected %b, got %b",
                                       want.final_item, m_axis_tlast));
                    if (m_axis_tdata[31:16] !== want.compare_total)
                        flag($sformatf("compare_total: expected %0d, got %0d",
                                       want.compare_total, m_axis_tdata[31:16]));
                    if (m_axis_tdata[47:32] !== want.move_total)
                        flag($sformatf("move_total: expected %0d, got %0d",
                                       want.move_total, m_axis_tdata[47:32]));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (key_cnt < CAPACITY) begin
                    key_buf[key_cnt] = s_axis_tdata;
                    key_cnt++;
                end
                if (s_axis_tlast) begin
                    cmp_sum  = 0;
                    move_sum = 0;
                    shell_sort_keys(key_cnt);
                    for (k = 0; k < key_cnt; k++) begin
                        want.sorted_value  = key_buf[k];
                        want.final_item    = (k + 1 == key_cnt);
                        want.compare_total = TOT_W'(cmp_sum);
                        want.move_total    = TOT_W'(move_sum);
                        sorted_q.push_back(want);
                    end
                    key_cnt = 0;
                end
            end
        end
        pending = sorted_q.size();
    end

endmodule

[tb/tb_shell_sort_with_counts.sv]
`timescale 1ns / 100ps
module tb_shell_sort_with_counts;
    import ssc_pkg::*;

    localparam int IDLE_LIMIT = 50000;
    localparam int SETTLE     = 8;
    localparam int KEY_TARGET = 200;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             cfg_wr_en     = 1'b0;
    logic [DIV_W-1:0] cfg_wr_data   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [15:0]      s_axis_tdata  = '0;
    logic             s_axis_tlast  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [47:0]      m_axis_tdata;
    logic             m_axis_tlast;

    int err_count;
    int pending;
    int burst_left  = 0;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int mode_cycles = 0;

    logic [DIV_W-1:0] div_plan [10] = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd2,
                                        4'd5, 4'd1, 4'd6, 4'd4, 4'd7};

    shell_sort_with_counts u_dut (.*);

    ssc_checker u_chk (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: always ready, random, or mostly stalled, switching now and then
    always @(negedge aclk) begin
        if (mode_cycles == 0) begin
            stall_mode  = $urandom_range(0, 2);
            mode_cycles = $urandom_range(20, 300);
        end
        mode_cycles--;
        unique case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_key(input logic [15:0] key, input logic last);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic set_divisor(input logic [DIV_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        int          i;
        int          n;
        int          sent;
        int          set_no;
        int          plan_idx;
        bit          narrow;
        logic [15:0] key;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single key: no gap from the divisor, closing pass only; then a two-key set
        send_key(16'hFFFF, 1'b1);
        send_key(16'h0000, 1'b0);
        send_key(16'hFFFF, 1'b1);
        // descending set, every key swapped
        for (i = 0; i < 8; i++)
            send_key(16'hFFFF - 16'(i) * 16'h2001, i == 7);
        // duplicates
        send_key(16'd7, 1'b0);
        send_key(16'd7, 1'b0);
        send_key(16'd0, 1'b0);
        send_key(16'd7, 1'b0);
        send_key(16'd0, 1'b1);
        // gap sequence 2 then 0: skips 1
        set_divisor(4'd3);
        for (i = 0; i < 6; i++)
            send_key($urandom_range(0, 65535), i == 5);

        sent     = 0;
        set_no   = 0;
        plan_idx = 0;
        while (sent < KEY_TARGET) begin
            if ($urandom_range(0, 2) == 0 || set_no == 2) begin
                set_divisor(div_plan[plan_idx % 10]);
                plan_idx++;
            end
            if (set_no == 2)
                n = CAPACITY;
            else if (set_no == 5)
                n = CAPACITY + 3;
            else
                n = $urandom_range(1, 12);
            narrow = ($urandom_range(0, 3) == 0);
            for (i = 0; i < n; i++) begin
                key = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535));
                send_key(key, i == n - 1);
            end
            sent += n;
            set_no++;
        end

        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
